### hw/rtl/fna_pkg.sv
// ----------------------------------------------------------------------------
// fna_pkg
// shared widths and constants of the frobenius norm accumulator
// ----------------------------------------------------------------------------
package fna_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF    = 52;

    // width of the reported norm, fixed by the result word
    localparam int NORM_WIDTH = 26;
    localparam logic [NORM_WIDTH-1:0] NORM_MAX = '1;

endpackage

### hw/rtl/fna_in_if.sv
// ----------------------------------------------------------------------------
// fna_in_if
// element channel: one matrix element per word
// ----------------------------------------------------------------------------
interface fna_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] real_part;
    logic signed [SAMPLE_WIDTH-1:0] imag_part;
    logic                           last;

    modport source (output valid, output real_part, output imag_part, output last,
                    input ready);
    modport sink   (input valid, input real_part, input imag_part, input last,
                    output ready);
endinterface

### hw/rtl/fna_out_if.sv
// ----------------------------------------------------------------------------
// fna_out_if
// result channel: one norm word per matrix
// ----------------------------------------------------------------------------
interface fna_out_if;
    import fna_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [NORM_WIDTH-1:0] norm_value;
    logic                  overflow;

    modport source (output valid, output norm_value, output overflow, input ready);
    modport sink   (input valid, input norm_value, input overflow, output ready);
endinterface

### hw/rtl/fna_cfg_if.sv
// ----------------------------------------------------------------------------
// fna_cfg_if
// configuration write channel carrying the complex mode bit
// ----------------------------------------------------------------------------
interface fna_cfg_if;
    logic valid;
    logic ready;
    logic complex_mode;

    modport source (output valid, output complex_mode, input ready);
    modport sink   (input valid, input complex_mode, output ready);
endinterface

### hw/rtl/fna_isqrt.sv
// ----------------------------------------------------------------------------
// fna_isqrt
// digit-by-digit floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module fna_isqrt #(
    parameter int ACC_WIDTH = fna_pkg::ACC_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ACC_WIDTH-1:0]           i_radicand,
    output logic                           o_done,
    output logic [(ACC_WIDTH+1)/2-1:0]     o_root
);
    import fna_pkg::*;

    localparam int ROOT_W = (ACC_WIDTH + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_trial;
    logic              w_fit;

    // bring down the next two radicand bits and try the next root bit
    assign w_rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
                r_rad  <= RAD_W'(i_radicand);
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], w_fit};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### hw/rtl/frobenius_norm_accumulator_core.sv
// ----------------------------------------------------------------------------
// frobenius_norm_accumulator_core
// saturating sum of squares over a matrix, floor square root on the last word
// ----------------------------------------------------------------------------
// flow: a non-last word passes a multiply state and an add state for each part
//   (real, then imaginary in complex mode, sharing one multiplier) before the input is freed
// last word: after the adds the bit-serial root runs, then the result word is loaded
//   into the output register once that register is free
// the next matrix may start while the result word still waits at the output
// reset: synchronous active low, clears sum, overflow flag, mode and valids
module frobenius_norm_accumulator_core #(
    parameter int SAMPLE_WIDTH = fna_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = fna_pkg::ACC_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fna_in_if.sink        i_in,
    fna_out_if.source     o_out,
    fna_cfg_if.sink       i_cfg
);
    import fna_pkg::*;

    localparam int TERM_W = 2 * SAMPLE_WIDTH;
    // sum plus one term never carries past this width
    localparam int SUM_W  = ((TERM_W > ACC_WIDTH) ? TERM_W : ACC_WIDTH) + 1;
    localparam int ROOT_W = (ACC_WIDTH + 1) / 2;
    localparam int EXT_W  = (ROOT_W > NORM_WIDTH) ? ROOT_W : NORM_WIDTH;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_ROOT,
        ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic r_complex_mode;

    // latched element word
    logic signed [SAMPLE_WIDTH-1:0] r_re;
    logic signed [SAMPLE_WIDTH-1:0] r_im;
    logic                           r_last;
    logic                           r_mode;
    logic                           r_phase_im;   // working on the imaginary part

    // accumulation
    logic [TERM_W-1:0]    r_term;
    logic [ACC_WIDTH-1:0] r_sum;
    logic                 r_sat;

    // root unit handshake
    logic r_sqrt_start;

    // output word register
    logic                  r_out_valid;
    logic [NORM_WIDTH-1:0] r_out_norm;
    logic                  r_out_ovf;

    logic [SAMPLE_WIDTH-1:0] w_sample;
    logic [SAMPLE_WIDTH-1:0] w_mag;
    logic [TERM_W-1:0]       w_square;
    logic [SUM_W-1:0]        w_total;
    logic [ACC_WIDTH-1:0]    n_sum;
    logic                    n_sat;
    logic                    w_sqrt_done;
    logic [ROOT_W-1:0]       w_root;
    logic [EXT_W-1:0]        w_root_ext;
    logic [NORM_WIDTH-1:0]   w_norm;
    logic                    w_out_free;
    logic                    w_out_load;

    // shared squarer: magnitude first so the most negative sample squares exactly
    assign w_sample = r_phase_im ? r_im : r_re;
    assign w_mag    = w_sample[SAMPLE_WIDTH-1] ? (~w_sample + SAMPLE_WIDTH'(1)) : w_sample;
    assign w_square = w_mag * w_mag;

    // saturating add of the registered term
    always_comb begin
        w_total = SUM_W'(r_sum) + SUM_W'(r_term);
        if (w_total > SUM_W'(ACC_MAX)) begin
            n_sum = ACC_MAX;
            n_sat = 1'b1;
        end else begin
            n_sum = w_total[ACC_WIDTH-1:0];
            n_sat = r_sat;
        end
    end

    fna_isqrt #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_radicand (r_sum),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // clamp the root to the result width
    assign w_root_ext = EXT_W'(w_root);
    assign w_norm     = (w_root_ext > EXT_W'(NORM_MAX)) ? NORM_MAX
                                                        : w_root_ext[NORM_WIDTH-1:0];

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = (r_state == ST_OUT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_complex_mode <= 1'b0;
            r_sum          <= '0;
            r_sat          <= 1'b0;
            r_sqrt_start   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase_im     <= 1'b0;
        end else begin
            r_sqrt_start <= 1'b0;

            if (i_cfg.valid) begin
                r_complex_mode <= i_cfg.complex_mode;
            end

            // result word leaves when taken, a new one may take its place
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_re       <= i_in.real_part;
                        r_im       <= i_in.imag_part;
                        r_last     <= i_in.last;
                        r_mode     <= r_complex_mode;
                        r_phase_im <= 1'b0;
                        r_state    <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_term  <= w_square;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_sum <= n_sum;
                    r_sat <= n_sat;
                    if (!r_phase_im && r_mode) begin
                        r_phase_im <= 1'b1;
                        r_state    <= ST_MUL;
                    end else if (r_last) begin
                        r_sqrt_start <= 1'b1;
                        r_state      <= ST_ROOT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_ROOT: begin
                    if (w_sqrt_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hand the root over once the output register is free,
                    // then start the next matrix from zero
                    if (w_out_load) begin
                        r_out_norm  <= w_norm;
                        r_out_ovf   <= r_sat;
                        r_sum       <= '0;
                        r_sat       <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.norm_value = r_out_norm;
    assign o_out.overflow   = r_out_ovf;

endmodule
